[src/mck_pkg.sv]
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and the dot/dash pattern table of the morse keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

    // widths of the configuration and payload fields
    localparam int TimeW    = 16;
    localparam int CharW    = 8;
    localparam int CfgIdxW  = 2;
    localparam int LenW     = 3;
    localparam int PatW     = 5;
    localparam int StepW    = 4;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_DOT_TIME  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DASH_TIME = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WORD_GAP  = 2'd2;

    // reset values of the timing registers, in ms
    localparam logic [TimeW-1:0] DOT_TIME_RST  = 16'(200 / 4);
    localparam logic [TimeW-1:0] DASH_TIME_RST = 16'(600 / 4);
    localparam logic [TimeW-1:0] WORD_GAP_RST  = 16'((200 / 4) * 7);

    // number of pattern table entries: 26 letters then 10 digits
    localparam int NumSlots = 36;
    localparam int SlotW    = 6;
    localparam logic [SlotW-1:0] DigitBase = 6'd26;

    // one request for the back part
    typedef struct packed {
        logic            is_space;
        logic [LenW-1:0] len;
        logic [PatW-1:0] bits;
    } t_cmd;

    typedef struct packed {
        logic [LenW-1:0] len;
        logic [PatW-1:0] bits;
    } t_pattern;

    // element i is bit (len-1-i); 1 is a dash
    function automatic t_pattern pattern_lookup(input logic [SlotW-1:0] slot);
        t_pattern p;
        case (slot)
            6'd0:    p = '{3'd2, 5'd1};
            6'd1:    p = '{3'd4, 5'd8};
            6'd2:    p = '{3'd4, 5'd10};
            6'd3:    p = '{3'd3, 5'd4};
            6'd4:    p = '{3'd1, 5'd0};
            6'd5:    p = '{3'd4, 5'd2};
            6'd6:    p = '{3'd3, 5'd6};
            6'd7:    p = '{3'd4, 5'd0};
            6'd8:    p = '{3'd2, 5'd0};
            6'd9:    p = '{3'd4, 5'd7};
            6'd10:   p = '{3'd3, 5'd5};
            6'd11:   p = '{3'd4, 5'd4};
            6'd12:   p = '{3'd2, 5'd3};
            6'd13:   p = '{3'd2, 5'd2};
            6'd14:   p = '{3'd3, 5'd7};
            6'd15:   p = '{3'd4, 5'd6};
            6'd16:   p = '{3'd4, 5'd13};
            6'd17:   p = '{3'd3, 5'd2};
            6'd18:   p = '{3'd3, 5'd0};
            6'd19:   p = '{3'd1, 5'd1};
            6'd20:   p = '{3'd3, 5'd1};
            6'd21:   p = '{3'd4, 5'd1};
            6'd22:   p = '{3'd3, 5'd3};
            6'd23:   p = '{3'd4, 5'd9};
            6'd24:   p = '{3'd4, 5'd11};
            6'd25:   p = '{3'd4, 5'd12};
            6'd26:   p = '{3'd5, 5'd31};
            6'd27:   p = '{3'd5, 5'd15};
            6'd28:   p = '{3'd5, 5'd7};
            6'd29:   p = '{3'd5, 5'd3};
            6'd30:   p = '{3'd5, 5'd1};
            6'd31:   p = '{3'd5, 5'd0};
            6'd32:   p = '{3'd5, 5'd16};
            6'd33:   p = '{3'd5, 5'd24};
            6'd34:   p = '{3'd5, 5'd28};
            6'd35:   p = '{3'd5, 5'd30};
            default: p = '{3'd1, 5'd0};
        endcase
        return p;
    endfunction

endpackage

[src/mck_front.sv]
// ----------------------------------------------------------------------------
// mck_front
// Classifies an incoming character and turns it into a keying request.
// ----------------------------------------------------------------------------
module mck_front (
    input  logic                      i_push,
    input  logic [mck_pkg::CharW-1:0] i_char_code,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output mck_pkg::t_cmd             o_cmd
);

    logic                      w_handled;
    logic                      w_is_space;
    logic [mck_pkg::SlotW-1:0] w_slot;
    mck_pkg::t_pattern         w_pat;

    // map the byte to a table slot, or to a space, or drop it
    always_comb begin
        w_handled  = 1'b1;
        w_slot     = '0;
        w_is_space = 1'b0;
        if (i_char_code inside {["a":"z"]}) begin
            w_slot = mck_pkg::SlotW'(i_char_code - 8'("a"));
        end else if (i_char_code inside {["A":"Z"]}) begin
            w_slot = mck_pkg::SlotW'(i_char_code - 8'("A"));
        end else if (i_char_code inside {["0":"9"]}) begin
            w_slot = mck_pkg::DigitBase + mck_pkg::SlotW'(i_char_code - 8'("0"));
        end else if (i_char_code == 8'(" ")) begin
            w_is_space = 1'b1;
        end else begin
            w_handled = 1'b0;
        end
    end

    // pattern lookup
    assign w_pat = mck_pkg::pattern_lookup(w_slot);
    assign o_cmd = '{is_space: w_is_space, len: w_pat.len, bits: w_pat.bits};

    // unhandled bytes are taken but cause no request
    assign o_q_push = i_push && !i_q_full && w_handled;

endmodule

[src/mck_cmd_queue.sv]
// ----------------------------------------------------------------------------
// mck_cmd_queue
// Short request queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module mck_cmd_queue #(
    parameter int DEPTH = mck_pkg::CMD_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mck_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mck_pkg::t_cmd o_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    mck_pkg::t_cmd    r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic             w_wr;
    logic             w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/mck_sequencer.sv]
// ----------------------------------------------------------------------------
// mck_sequencer
// Steps through one request into the output register, one keying interval per
// cycle while the output register is free or being popped.
// ----------------------------------------------------------------------------
module mck_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  mck_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_pop,
    input  logic [mck_pkg::TimeW-1:0] i_dot_time,
    input  logic [mck_pkg::TimeW-1:0] i_dash_time,
    input  logic [mck_pkg::TimeW-1:0] i_word_gap_time,
    input  logic                      i_pop,
    output logic                      o_empty,
    output logic                      o_key_on,
    output logic [mck_pkg::TimeW-1:0] o_interval,
    output logic                      o_last
);

    logic                       r_act;
    mck_pkg::t_cmd              r_cmd;
    logic [mck_pkg::StepW-1:0]  r_idx;
    logic                       r_out_valid;
    logic                       r_key_on;
    logic [mck_pkg::TimeW-1:0]  r_interval;
    logic                       r_last;

    logic                       w_out_ready;
    logic                       w_emit;
    logic                       w_done;
    logic                       w_key_on;
    logic [mck_pkg::TimeW-1:0]  w_interval;
    logic                       w_last;
    logic [mck_pkg::LenW-1:0]   w_shift;
    logic                       w_dash;

    // which element the current step belongs to, and whether it is a dash
    assign w_shift = r_cmd.len - 3'd1 - r_idx[mck_pkg::StepW-1:1];
    assign w_dash  = r_cmd.bits[0 +: 1] == 1'b1 && w_shift == '0
                   ? 1'b1 : ((r_cmd.bits >> w_shift) & 5'd1) != 5'd0;

    // interval for the current step
    always_comb begin
        if (r_cmd.is_space) begin
            w_key_on   = 1'b0;
            w_interval = i_word_gap_time;
            w_last     = 1'b1;
        end else if (r_idx == {r_cmd.len, 1'b0}) begin
            w_key_on   = 1'b0;
            w_interval = i_dash_time;
            w_last     = 1'b1;
        end else if (!r_idx[0]) begin
            w_key_on   = 1'b1;
            w_interval = w_dash ? i_dash_time : i_dot_time;
            w_last     = 1'b0;
        end else begin
            w_key_on   = 1'b0;
            w_interval = i_dot_time;
            w_last     = 1'b0;
        end
    end

    assign w_out_ready = !r_out_valid || i_pop;
    assign w_emit      = r_act && w_out_ready;
    assign w_done      = w_emit && w_last;
    assign o_cmd_pop   = i_cmd_valid && (!r_act || w_done);

    // request walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
        end else if (o_cmd_pop) begin
            r_act <= 1'b1;
            r_idx <= '0;
        end else if (w_done) begin
            r_act <= 1'b0;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_key_on   <= w_key_on;
            r_interval <= w_interval;
            r_last     <= w_last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_key_on   = r_key_on;
    assign o_interval = r_interval;
    assign o_last     = r_last;

endmodule

[src/morse_character_keyer.sv]
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns ASCII characters into timed key-on and key-off intervals.
// ----------------------------------------------------------------------------
// first interval of a character passes the queue, the sequencer request register and the output register
// throughput: one interval per cycle while the output register is free or being popped;
//   a character gives 2*elements+1 intervals (1 to 11), emitted by the sequencer
// new characters are taken while a request waits in the two-entry queue
// reset: synchronous, clears queue and output; timing registers go to 50/150/350
// ----------------------------------------------------------------------------
module morse_character_keyer #(
    parameter int CMD_DEPTH = mck_pkg::CMD_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [mck_pkg::CharW-1:0]   i_char_code,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic                        o_key_on,
    output logic [mck_pkg::TimeW-1:0]   o_interval,
    output logic                        o_last,
    input  logic                        i_cfg_wr_en,
    input  logic [mck_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [mck_pkg::TimeW-1:0]   i_cfg_data
);

    logic [mck_pkg::TimeW-1:0] r_dot_time;
    logic [mck_pkg::TimeW-1:0] r_dash_time;
    logic [mck_pkg::TimeW-1:0] r_word_gap_time;

    logic          w_q_push;
    mck_pkg::t_cmd w_front_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    mck_pkg::t_cmd w_cmd;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_time      <= mck_pkg::DOT_TIME_RST;
            r_dash_time     <= mck_pkg::DASH_TIME_RST;
            r_word_gap_time <= mck_pkg::WORD_GAP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mck_pkg::CFG_DOT_TIME:  r_dot_time      <= i_cfg_data;
                mck_pkg::CFG_DASH_TIME: r_dash_time     <= i_cfg_data;
                mck_pkg::CFG_WORD_GAP:  r_word_gap_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classifier
    mck_front u_front (
        .i_push      (i_push),
        .i_char_code (i_char_code),
        .i_q_full    (o_full),
        .o_q_push    (w_q_push),
        .o_cmd       (w_front_cmd)
    );

    // request queue
    mck_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (o_full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_cmd)
    );

    // interval sequencer
    mck_sequencer u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .i_dot_time      (r_dot_time),
        .i_dash_time     (r_dash_time),
        .i_word_gap_time (r_word_gap_time),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_key_on        (o_key_on),
        .o_interval      (o_interval),
        .o_last          (o_last)
    );

    // output is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_empty)
        else $error("result shown right after reset");

    // the closing interval of a character is always key-off
    a_last_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> !o_key_on)
        else $error("final interval has key on");

    // the sequencer never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd_valid |-> !w_cmd_pop)
        else $error("request taken from empty queue");

endmodule
